@@ hdl/fid_pkg.sv @@
// ----------------------------------------------------------------------------
// fid_pkg
// Shared types, constants and the helper function of the free id allocator.
// ----------------------------------------------------------------------------
package fid_pkg;

  localparam int ID_COUNT = 64;
  localparam int MAP_W    = 64;
  localparam logic [MAP_W-1:0] VALID_MASK =
    (ID_COUNT >= MAP_W) ? {MAP_W{1'b1}} : ((64'd1 << ID_COUNT) - 64'd1);

  // Value of the lowest free id when nothing is free.
  localparam logic [6:0] NONE_FREE = 7'd64;

  typedef enum logic [2:0] {
    CMD_ALLOC         = 3'd0,
    CMD_ALLOC_LIMIT   = 3'd1,
    CMD_RESERVE       = 3'd2,
    CMD_RESERVE_RANGE = 3'd3,
    CMD_RUN           = 3'd4,
    CMD_ALLOC_MASK    = 3'd5,
    CMD_RUN_MASK      = 3'd6,
    CMD_QUERY         = 3'd7
  } cmd_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [5:0]       first_index;
    logic [5:0]       last_index;
    logic [6:0]       run_count;
    logic [6:0]       limit;
    logic [MAP_W-1:0] allow_mask;
  } item_t;

  typedef struct packed {
    logic [5:0] id;
    logic       found;
    logic [6:0] lowest_free;
  } result_t;

  // Index of the lowest set bit, NONE_FREE if no bit is set.
  function automatic logic [6:0] lowest_set(input logic [MAP_W-1:0] v);
    logic [6:0] pos;
    pos = NONE_FREE;
    for (int i = MAP_W - 1; i >= 0; i--) begin
      if (v[i]) pos = 7'(i);
    end
    return pos;
  endfunction

endpackage

@@ hdl/fid_in_stage.sv @@
// ----------------------------------------------------------------------------
// fid_in_stage
// Input register: captures one command beat per cycle.
// ----------------------------------------------------------------------------
module fid_in_stage import fid_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [2:0]  cmd,
  input  logic [5:0]  first_index,
  input  logic [5:0]  last_index,
  input  logic [6:0]  run_count,
  input  logic [6:0]  limit,
  input  logic [63:0] allow_mask,
  output logic        item_valid,
  output item_t       item
);

  logic  valid_r;
  item_t item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.cmd         <= cmd_t'(cmd);
      item_r.first_index <= first_index;
      item_r.last_index  <= last_index;
      item_r.run_count   <= run_count;
      item_r.limit       <= limit;
      item_r.allow_mask  <= allow_mask;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

@@ hdl/fid_exec.sv @@
// ----------------------------------------------------------------------------
// fid_exec
// Combinational command execution: searches the free map, builds the
// updated map and the result of one command.
// ----------------------------------------------------------------------------
module fid_exec import fid_pkg::*; (
  input  item_t            item,
  input  logic [MAP_W-1:0] free_map,
  output logic [MAP_W-1:0] map_nxt,
  output result_t          res
);

  logic [MAP_W-1:0] m;
  logic [MAP_W-1:0] thermo;
  logic [MAP_W-1:0] fit;
  logic [MAP_W-1:0] range_bits;
  logic [MAP_W-1:0] one_bit;
  logic [6:0]       lo_pos;
  logic [6:0]       run_pos;
  logic [6:0]       free_pos;
  logic             use_mask;

  always_comb begin
    use_mask = (item.cmd == CMD_ALLOC_MASK) || (item.cmd == CMD_RUN_MASK);
    m        = use_mask ? (free_map & item.allow_mask) : free_map;
    lo_pos   = lowest_set(m);
    free_pos = lowest_set(free_map);

    // Run of count low ones; counts above the map width never fit.
    thermo = (item.run_count >= 7'(MAP_W)) ? {MAP_W{1'b1}}
           : ((64'd1 << item.run_count[5:0]) - 64'd1);

    // A run fits at p when no taken id lies in its window and it ends in the map.
    for (int p = 0; p < MAP_W; p++) begin
      fit[p] = ((((~m) >> p) & thermo) == '0) &&
               ((8'(p) + {1'b0, item.run_count}) <= 8'(MAP_W));
    end
    run_pos = lowest_set(fit);

    range_bits = ({MAP_W{1'b1}} << item.first_index) &
                 ({MAP_W{1'b1}} >> (6'd63 - item.last_index)) & free_map;
    one_bit    = 64'd1 << item.first_index;

    map_nxt   = free_map;
    res.id    = '0;
    res.found = 1'b0;

    unique case (item.cmd)
      CMD_ALLOC, CMD_ALLOC_LIMIT, CMD_ALLOC_MASK: begin
        if (lo_pos != NONE_FREE &&
            (item.cmd != CMD_ALLOC_LIMIT || lo_pos < item.limit)) begin
          res.id    = lo_pos[5:0];
          res.found = 1'b1;
          map_nxt   = free_map & ~(64'd1 << lo_pos[5:0]);
        end
      end
      CMD_RESERVE: begin
        res.id = item.first_index;
        if ((free_map & one_bit) != '0) begin
          res.found = 1'b1;
          map_nxt   = free_map & ~one_bit;
        end
      end
      CMD_RESERVE_RANGE: begin
        res.id = item.first_index;
        if (range_bits != '0) begin
          res.found = 1'b1;
          map_nxt   = free_map & ~range_bits;
        end
      end
      CMD_RUN, CMD_RUN_MASK: begin
        if (item.run_count == '0) begin
          res.found = 1'b1;
        end else if (run_pos != NONE_FREE) begin
          res.id    = run_pos[5:0];
          res.found = 1'b1;
          map_nxt   = free_map & ~(thermo << run_pos[5:0]);
        end
      end
      CMD_QUERY: begin
        if (free_pos != NONE_FREE) begin
          res.id    = free_pos[5:0];
          res.found = 1'b1;
        end
      end
      default: begin
        map_nxt = free_map;
      end
    endcase

    map_nxt         = map_nxt & VALID_MASK;
    res.lowest_free = lowest_set(map_nxt);
  end

endmodule

@@ hdl/fid_state.sv @@
// ----------------------------------------------------------------------------
// fid_state
// Free map register and result register.
// ----------------------------------------------------------------------------
module fid_state import fid_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_valid,
  input  logic [MAP_W-1:0] map_nxt,
  input  result_t          res,
  output logic [MAP_W-1:0] free_map,
  output logic             out_valid,
  output result_t          out_res
);

  logic [MAP_W-1:0] free_map_r;
  logic             out_valid_r;
  result_t          out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_map_r  <= VALID_MASK;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= item_valid;
      if (item_valid) begin
        free_map_r <= map_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid) begin
      out_res_r <= res;
    end
  end

  assign free_map  = free_map_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

@@ hdl/free_id_set_allocator_top.sv @@
// ----------------------------------------------------------------------------
// free_id_set_allocator_top
// Free id allocator over a 64-entry bitmap of free ids.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat is taken at a rising edge where start is high and busy is
//   low. busy is never raised, so one command can be issued in every cycle.
//   in_cmd selects allocate lowest, allocate below a limit, reserve one id,
//   reserve a range, allocate a run, allocate inside a mask, run inside a
//   mask, or query. The other in_ fields are used as the command needs them.
//   Each command gives exactly one result beat, after the input register and
//   the result register: out_valid is high for one cycle with out_id,
//   out_found and out_lowest_free (64 when no id is free). The throughput
//   is one command per cycle; the single free-map register is read and
//   updated in the execute cycle, so back-to-back commands see each
//   other's effect. The result beat cannot be stalled by the receiver.
//   Reset (rst_n low at a clock edge) marks every id free and drops any
//   command in flight.
// ----------------------------------------------------------------------------
module free_id_set_allocator_top import fid_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_cmd,
  input  logic [5:0]  in_first_index,
  input  logic [5:0]  in_last_index,
  input  logic [6:0]  in_run_count,
  input  logic [6:0]  in_limit,
  input  logic [63:0] in_allow_mask,
  output logic        out_valid,
  output logic [5:0]  out_id,
  output logic        out_found,
  output logic [6:0]  out_lowest_free
);

  logic             item_valid;
  item_t            item;
  logic [MAP_W-1:0] free_map;
  logic [MAP_W-1:0] map_nxt;
  result_t          res;
  result_t          out_res;

  assign busy = 1'b0;

  fid_in_stage u_in (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (start && !busy),
    .cmd         (in_cmd),
    .first_index (in_first_index),
    .last_index  (in_last_index),
    .run_count   (in_run_count),
    .limit       (in_limit),
    .allow_mask  (in_allow_mask),
    .item_valid  (item_valid),
    .item        (item)
  );

  fid_exec u_exec (
    .item     (item),
    .free_map (free_map),
    .map_nxt  (map_nxt),
    .res      (res)
  );

  fid_state u_state (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .map_nxt    (map_nxt),
    .res        (res),
    .free_map   (free_map),
    .out_valid  (out_valid),
    .out_res    (out_res)
  );

  assign out_id          = out_res.id;
  assign out_found       = out_res.found;
  assign out_lowest_free = out_res.lowest_free;

endmodule

@@ hdl/fid_checker.sv @@
// ----------------------------------------------------------------------------
// fid_checker
// Port-level checks of the free id allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fid_checker import fid_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [2:0]  in_cmd,
  input logic [5:0]  in_first_index,
  input logic        out_valid,
  input logic [5:0]  out_id,
  input logic [6:0]  out_lowest_free
);

  // Every accepted beat yields a result after the input and result registers.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("accepted command produced no result");

  // No result appears without an accepted command that passed both registers.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without a command");

  // A reserve echoes the requested id.
  a_reserve_echo: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == CMD_RESERVE) |=> ##1
      (out_id == $past(in_first_index, 2)))
    else $error("reserve result does not echo its id");

  // The lowest free id is never beyond the none-free code.
  a_lowest_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_lowest_free <= NONE_FREE))
    else $error("lowest free id out of range");

endmodule

bind free_id_set_allocator_top fid_checker u_fid_checker (.*);
